### rtl/core/dvr_pkg.sv
// ----------------------------------------------------------------------------
// dvr_pkg
// Request codes, status codes, field widths and shared types of the
// distance-vector route table engine.
// ----------------------------------------------------------------------------
package dvr_pkg;

    localparam int NODE_ID_BITS = 4;
    localparam int COST_IO_BITS = 16;
    localparam int REQ_BITS     = 2;

    localparam logic [REQ_BITS-1:0] REQ_ADD_NBR = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_ADVERT  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_READ    = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NON_NBR = 1'b1;

    typedef logic [NODE_ID_BITS-1:0] t_node_id;
    typedef logic [COST_IO_BITS-1:0] t_cost_io;

    // table write enables out of the update logic
    typedef struct packed {
        logic route_we;
        logic nbr_we;
    } t_wr_en;

    // one result beat
    typedef struct packed {
        t_node_id entry_dest;
        t_cost_io entry_cost;
        t_node_id entry_next_hop;
        logic     entry_known;
        logic     entry_changed;
        logic     status;
    } t_result;

endpackage

### rtl/core/dvr_req_if.sv
// ----------------------------------------------------------------------------
// dvr_req_if
// Request channel: valid/ready handshake with one request beat as payload.
// ----------------------------------------------------------------------------
interface dvr_req_if;
    import dvr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_BITS-1:0]     req_type;
    logic [NODE_ID_BITS-1:0] node_id;
    logic [NODE_ID_BITS-1:0] dest_id;
    logic [COST_IO_BITS-1:0] cost_in;

    modport source (output valid, output req_type, output node_id, output dest_id,
                    output cost_in, input ready);
    modport sink   (input valid, input req_type, input node_id, input dest_id,
                    input cost_in, output ready);
endinterface

### rtl/core/dvr_rsp_if.sv
// ----------------------------------------------------------------------------
// dvr_rsp_if
// Result channel: valid/ready handshake with one table entry report as payload.
// ----------------------------------------------------------------------------
interface dvr_rsp_if;
    import dvr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [NODE_ID_BITS-1:0] entry_dest;
    logic [COST_IO_BITS-1:0] entry_cost;
    logic [NODE_ID_BITS-1:0] entry_next_hop;
    logic                    entry_known;
    logic                    entry_changed;
    logic                    status;

    modport source (output valid, output entry_dest, output entry_cost,
                    output entry_next_hop, output entry_known, output entry_changed,
                    output status, input ready);
    modport sink   (input valid, input entry_dest, input entry_cost,
                    input entry_next_hop, input entry_known, input entry_changed,
                    input status, output ready);
endinterface

### rtl/core/dvr_table.sv
// ----------------------------------------------------------------------------
// dvr_table
// One table: a synchronous data memory with one write and one registered
// read port, plus a valid bit per entry that reset clears.
// ----------------------------------------------------------------------------
module dvr_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic                     o_rvalid,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic             r_rvalid;
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rvalid = r_rvalid;
    assign o_rdata  = r_rdata;
endmodule

### rtl/core/dvr_update.sv
// ----------------------------------------------------------------------------
// dvr_update
// Bellman-Ford relax step: decides the table writes for one request from
// the entries read out, and forms the report of the entry after the step.
// ----------------------------------------------------------------------------
module dvr_update #(
    parameter int NODE_COUNT = 16,
    parameter int COST_BITS  = 16
) (
    input  logic [1:0]              i_req_type,
    input  dvr_pkg::t_node_id       i_node,
    input  dvr_pkg::t_node_id       i_dest,
    input  logic [COST_BITS-1:0]    i_cost,
    input  dvr_pkg::t_node_id       i_self,
    input  logic                    i_route_known,
    input  logic [COST_BITS-1:0]    i_route_cost,
    input  dvr_pkg::t_node_id       i_route_hop,
    input  logic                    i_nbr_present,
    input  logic [COST_BITS-1:0]    i_link_cost,
    output dvr_pkg::t_wr_en         o_wr,
    output logic [COST_BITS+3:0]    o_route_wdata,
    output logic [COST_BITS-1:0]    o_nbr_wdata,
    output dvr_pkg::t_result        o_result
);
    import dvr_pkg::*;

    logic                   node_ok;
    logic                   dest_ok;
    logic [COST_BITS:0]     sum;
    logic [COST_BITS-1:0]   cand;
    t_node_id               rep_dest;
    logic                   rep_ok;
    logic [COST_BITS-1:0]   new_cost;
    t_node_id               new_hop;
    logic                   changed;
    logic                   bad;
    logic [COST_BITS-1:0]   rep_cost;
    t_node_id               rep_hop;
    logic                   rep_known;
    logic [COST_BITS+15:0]  cost_wide;

    assign node_ok = 32'(i_node) < 32'(NODE_COUNT);
    assign dest_ok = 32'(i_dest) < 32'(NODE_COUNT);

    // saturate the candidate at the cost maximum
    assign sum  = {1'b0, i_cost} + {1'b0, i_link_cost};
    assign cand = sum[COST_BITS] ? '1 : sum[COST_BITS-1:0];

    always_comb begin
        o_wr     = '0;
        changed  = 1'b0;
        bad      = 1'b0;
        new_cost = i_cost;
        new_hop  = i_node;
        rep_dest = i_dest;
        rep_ok   = dest_ok;
        case (i_req_type)
            REQ_ADD_NBR: begin
                rep_dest = i_node;
                rep_ok   = node_ok;
                if (node_ok) begin
                    o_wr.nbr_we = 1'b1;
                    if (i_node != i_self) begin
                        o_wr.route_we = 1'b1;
                        changed       = 1'b1;
                    end
                end
            end
            REQ_ADVERT: begin
                new_cost = cand;
                if (!node_ok || !i_nbr_present) begin
                    bad = 1'b1;
                end else if (dest_ok && (i_dest != i_self)) begin
                    if (!i_route_known || (cand < i_route_cost)) begin
                        o_wr.route_we = 1'b1;
                        changed       = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rep_cost  = '0;
        rep_hop   = '0;
        rep_known = 1'b0;
        if (rep_dest == i_self) begin
            rep_hop   = i_self;
            rep_known = 1'b1;
        end else if (changed) begin
            rep_cost  = new_cost;
            rep_hop   = new_hop;
            rep_known = 1'b1;
        end else if (rep_ok && i_route_known) begin
            rep_cost  = i_route_cost;
            rep_hop   = i_route_hop;
            rep_known = 1'b1;
        end
    end

    assign cost_wide     = {16'd0, rep_cost};
    assign o_route_wdata = {new_cost, new_hop};
    assign o_nbr_wdata   = i_cost;

    assign o_result.entry_dest     = rep_dest;
    assign o_result.entry_cost     = cost_wide[15:0];
    assign o_result.entry_next_hop = rep_hop;
    assign o_result.entry_known    = rep_known;
    assign o_result.entry_changed  = changed;
    assign o_result.status         = bad ? STATUS_NON_NBR : STATUS_OK;
endmodule

### rtl/core/distance_vector_route_update.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update
// Distance-vector route table engine of one router: neighbor adds,
// advertisement relax steps and table reads, one result beat per request.
// ----------------------------------------------------------------------------
// Each request beat is taken into a read stage while the route and neighbor
// memories are read; the read stage then computes the update, writes it back
// and loads the result register. A new request is accepted only once the
// previous one has written back, so the block takes no new request before
// the last is through, set by the read-then-write turnaround of the memories;
// a full result register that is not taken holds the read stage. Known and
// neighbor-present marks are flip-flops cleared by reset, so no clearing pass
// is needed. The user must write self_node through i_cfg_we / i_cfg_wdata
// only while no request is in flight; the block does not enforce it, and
// self_node always reports cost 0 with itself as next hop.
module distance_vector_route_update #(
    parameter int NODE_COUNT = 16,
    parameter int COST_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  dvr_pkg::t_node_id      i_cfg_wdata,
    dvr_req_if.sink                i_req,
    dvr_rsp_if.source              o_rsp
);
    import dvr_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);

    t_node_id               r_self;
    logic                   r_s1_valid;
    logic [REQ_BITS-1:0]    r_type;
    t_node_id               r_node;
    t_node_id               r_dest;
    logic [COST_BITS-1:0]   r_cost;
    logic [AW-1:0]          r_route_addr;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   in_fire;
    logic                   s1_done;
    logic [COST_BITS+15:0]  cost_in_wide;
    t_node_id               route_rd_id;
    logic                   route_known;
    logic [COST_BITS+3:0]   route_rdata;
    logic                   nbr_present;
    logic [COST_BITS-1:0]   link_cost;
    t_wr_en                 wr;
    logic [COST_BITS+3:0]   route_wdata;
    logic [COST_BITS-1:0]   nbr_wdata;
    t_result                result;

    assign i_req.ready = !r_s1_valid;
    assign in_fire     = i_req.valid && !r_s1_valid;
    assign s1_done     = r_s1_valid && (!r_out_valid || o_rsp.ready);

    assign cost_in_wide = {{COST_BITS{1'b0}}, i_req.cost_in};
    // an add reports the neighbor's own route, everything else the destination
    assign route_rd_id  = (i_req.req_type == REQ_ADD_NBR) ? i_req.node_id : i_req.dest_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_self <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_type       <= i_req.req_type;
            r_node       <= i_req.node_id;
            r_dest       <= i_req.dest_id;
            r_cost       <= cost_in_wide[COST_BITS-1:0];
            r_route_addr <= AW'(route_rd_id);
        end
        if (s1_done) begin
            r_out <= result;
        end
    end

    dvr_table #(
        .DEPTH (NODE_COUNT),
        .WIDTH (COST_BITS + NODE_ID_BITS)
    ) u_route (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (s1_done && wr.route_we),
        .i_waddr  (r_route_addr),
        .i_wdata  (route_wdata),
        .i_re     (in_fire),
        .i_raddr  (AW'(route_rd_id)),
        .o_rvalid (route_known),
        .o_rdata  (route_rdata)
    );

    dvr_table #(
        .DEPTH (NODE_COUNT),
        .WIDTH (COST_BITS)
    ) u_nbr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (s1_done && wr.nbr_we),
        .i_waddr  (AW'(r_node)),
        .i_wdata  (nbr_wdata),
        .i_re     (in_fire),
        .i_raddr  (AW'(i_req.node_id)),
        .o_rvalid (nbr_present),
        .o_rdata  (link_cost)
    );

    dvr_update #(
        .NODE_COUNT (NODE_COUNT),
        .COST_BITS  (COST_BITS)
    ) u_update (
        .i_req_type    (r_type),
        .i_node        (r_node),
        .i_dest        (r_dest),
        .i_cost        (r_cost),
        .i_self        (r_self),
        .i_route_known (route_known),
        .i_route_cost  (route_rdata[COST_BITS+3:4]),
        .i_route_hop   (route_rdata[3:0]),
        .i_nbr_present (nbr_present),
        .i_link_cost   (link_cost),
        .o_wr          (wr),
        .o_route_wdata (route_wdata),
        .o_nbr_wdata   (nbr_wdata),
        .o_result      (result)
    );

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.entry_dest     = r_out.entry_dest;
    assign o_rsp.entry_cost     = r_out.entry_cost;
    assign o_rsp.entry_next_hop = r_out.entry_next_hop;
    assign o_rsp.entry_known    = r_out.entry_known;
    assign o_rsp.entry_changed  = r_out.entry_changed;
    assign o_rsp.status         = r_out.status;
endmodule
